@@ rtl/linear_array_queue_with_search_core_assert.svh @@
// Assertion macros used by the queue-with-search controller RTL.
`ifndef LINEAR_ARRAY_QUEUE_WITH_SEARCH_CORE_ASSERT_SVH
`define LINEAR_ARRAY_QUEUE_WITH_SEARCH_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LAQS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LAQS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/laqs_pkg.sv @@
// Package for the linear array queue with search: sizes, codes, payload and control types.
package laqs_pkg;

    localparam int DEPTH  = 128;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int POS_W  = 7;

    localparam logic [1:0] KIND_ENQ  = 2'd0;
    localparam logic [1:0] KIND_DEQ  = 2'd1;
    localparam logic [1:0] KIND_SRCH = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] data;
        logic [POS_W-1:0]         position;
    } rsp_t;

    // Which result to capture into the pending result register.
    typedef enum logic [2:0] {
        RES_NONE,
        RES_OK,
        RES_FULL,
        RES_EMPTY,
        RES_NOTFOUND,
        RES_DATA,
        RES_POS
    } res_sel_t;

    typedef struct packed {
        logic     enq_write;
        logic     rd_head;
        logic     deq_pop;
        logic     scan_next;
        logic     out_load;
        res_sel_t res_sel;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic match;
        logic at_tail;
    } stat_t;

endpackage

@@ rtl/laqs_datapath.sv @@
// Datapath: slot memory, queue indices, search scan and result registers.
module laqs_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  laqs_pkg::cmd_t cmd,
    input  laqs_pkg::req_t req,
    output laqs_pkg::stat_t stat,
    output laqs_pkg::rsp_t rsp
);

    logic signed [laqs_pkg::DATA_W-1:0] mem [laqs_pkg::DEPTH];

    logic [laqs_pkg::IDX_W-1:0]  head_reg, head_next;
    logic [laqs_pkg::IDX_W-1:0]  tail_reg, tail_next;
    logic [laqs_pkg::CNT_W-1:0]  filled_reg, filled_next;
    logic                        empty_reg, empty_next;
    logic [laqs_pkg::IDX_W-1:0]  scan_reg, scan_next;
    logic signed [laqs_pkg::DATA_W-1:0] key_reg;
    logic signed [laqs_pkg::DATA_W-1:0] rdata_reg;
    laqs_pkg::rsp_t              res_reg, res_next;
    laqs_pkg::rsp_t              rsp_reg;

    logic                        rd_en;
    logic [laqs_pkg::IDX_W-1:0]  raddr;

    assign rd_en = cmd.rd_head | cmd.scan_next;
    assign raddr = cmd.rd_head ? head_reg : scan_next;

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.enq_write)
        begin
            mem[filled_reg[laqs_pkg::IDX_W-1:0]] <= req.value;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        filled_next = filled_reg;
        empty_next  = empty_reg;
        if (cmd.enq_write)
        begin
            if (empty_reg)
            begin
                head_next = '0;
            end
            tail_next   = filled_reg[laqs_pkg::IDX_W-1:0];
            filled_next = filled_reg + laqs_pkg::CNT_W'(1);
            empty_next  = 1'b0;
        end
        else if (cmd.deq_pop)
        begin
            if (head_reg == tail_reg)
            begin
                // last entry left: back to the empty state
                head_next   = '0;
                tail_next   = '0;
                filled_next = '0;
                empty_next  = 1'b1;
            end
            else
            begin
                head_next = head_reg + laqs_pkg::IDX_W'(1);
            end
        end
    end

    assign scan_next = cmd.rd_head ? head_reg
                     : (cmd.scan_next ? scan_reg + laqs_pkg::IDX_W'(1) : scan_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            filled_reg <= '0;
            empty_reg  <= 1'b1;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            filled_reg <= filled_next;
            empty_reg  <= empty_next;
        end
    end

    always_comb
    begin
        res_next = res_reg;
        case (cmd.res_sel)
            laqs_pkg::RES_NONE:     res_next = res_reg;
            laqs_pkg::RES_OK:       res_next = '{laqs_pkg::ST_OK, '0, '0};
            laqs_pkg::RES_FULL:     res_next = '{laqs_pkg::ST_FULL, '0, '0};
            laqs_pkg::RES_EMPTY:    res_next = '{laqs_pkg::ST_EMPTY, '0, '0};
            laqs_pkg::RES_NOTFOUND: res_next = '{laqs_pkg::ST_NOTFOUND, '0, '0};
            laqs_pkg::RES_DATA:     res_next = '{laqs_pkg::ST_OK, rdata_reg, '0};
            laqs_pkg::RES_POS:      res_next = '{laqs_pkg::ST_OK, '0,
                                                 laqs_pkg::POS_W'(scan_reg)};
            default:                res_next = res_reg;
        endcase
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        res_reg  <= res_next;
        if (cmd.rd_head)
        begin
            key_reg <= req.value;
        end
        if (cmd.out_load)
        begin
            rsp_reg <= res_reg;
        end
    end

    assign stat.full    = (filled_reg >= laqs_pkg::CNT_W'(laqs_pkg::DEPTH));
    assign stat.empty   = empty_reg;
    assign stat.match   = (rdata_reg == key_reg);
    assign stat.at_tail = (scan_reg == tail_reg);
    assign rsp          = rsp_reg;

endmodule

@@ rtl/laqs_ctrl.sv @@
// Controller: sequences each request and drives the response handshake.
`include "linear_array_queue_with_search_core_assert.svh"

module laqs_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  logic [1:0]      req_kind,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    input  laqs_pkg::stat_t stat,
    output laqs_pkg::cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEQ_WAIT,
        S_SRCH,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   out_free;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next    = state_reg;
        cmd.enq_write = 1'b0;
        cmd.rd_head   = 1'b0;
        cmd.deq_pop   = 1'b0;
        cmd.scan_next = 1'b0;
        cmd.out_load  = 1'b0;
        cmd.res_sel   = laqs_pkg::RES_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DONE;
                    case (req_kind)
                        laqs_pkg::KIND_ENQ:
                        begin
                            if (stat.full)
                            begin
                                cmd.res_sel = laqs_pkg::RES_FULL;
                            end
                            else
                            begin
                                cmd.enq_write = 1'b1;
                                cmd.res_sel   = laqs_pkg::RES_OK;
                            end
                        end
                        laqs_pkg::KIND_DEQ:
                        begin
                            if (stat.empty)
                            begin
                                cmd.res_sel = laqs_pkg::RES_EMPTY;
                            end
                            else
                            begin
                                cmd.rd_head = 1'b1;
                                state_next  = S_DEQ_WAIT;
                            end
                        end
                        laqs_pkg::KIND_SRCH:
                        begin
                            if (stat.empty)
                            begin
                                cmd.res_sel = laqs_pkg::RES_NOTFOUND;
                            end
                            else
                            begin
                                cmd.rd_head = 1'b1;
                                state_next  = S_SRCH;
                            end
                        end
                        default:
                        begin
                            cmd.res_sel = laqs_pkg::RES_OK;
                        end
                    endcase
                end
            end
            S_DEQ_WAIT:
            begin
                cmd.deq_pop = 1'b1;
                cmd.res_sel = laqs_pkg::RES_DATA;
                state_next  = S_DONE;
            end
            S_SRCH:
            begin
                if (stat.match)
                begin
                    cmd.res_sel = laqs_pkg::RES_POS;
                    state_next  = S_DONE;
                end
                else if (stat.at_tail)
                begin
                    cmd.res_sel = laqs_pkg::RES_NOTFOUND;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    `LAQS_ASSERT_NOW(a_srch_nonempty, state_reg == S_SRCH, !stat.empty, "search on empty queue")
    `LAQS_ASSERT_NEXT(a_deq_one_cycle, state_reg == S_DEQ_WAIT, state_reg == S_DONE, "dequeue stuck")
    `LAQS_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "request taken twice")
    `LAQS_ASSERT_NEXT(a_load_sets_valid, cmd.out_load, rsp_valid, "response lost")

endmodule

@@ rtl/linear_array_queue_with_search_core.sv @@
// Linear array queue with search: top level joining controller and datapath.
//
// Request channel (req_valid / req_ready / req): req.kind selects enqueue,
// dequeue or search; req.value is the value to enqueue or to look for.
// Response channel (rsp_valid / rsp_ready / rsp): one response per request,
// in order, carrying status, dequeued data and the slot position of a match.
//
// Timing: a request is taken only while the controller is idle. Enqueue,
// refused dequeue, empty search and the unused kind go from idle straight
// to the done state; a dequeue first waits for the registered head read.
// A search reads one slot per cycle through the registered memory port,
// from the head until the match or the tail. The controller returns to
// idle once the result moves into the output register, so the next
// request is taken while a response still waits on a stalled receiver;
// it then holds its result until rsp_ready.
//
// Reset (rst_n, asynchronous, active low) empties the queue and drops any
// pending response; slot contents are not cleared and need no clearing pass.
module linear_array_queue_with_search_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  laqs_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output laqs_pkg::rsp_t rsp
);

    // Command and status buses between sequencer and datapath.
    laqs_pkg::cmd_t  cmd;
    laqs_pkg::stat_t stat;

    // Sequence each request and own both handshakes.
    laqs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_kind  (req.kind),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Hold slots, indices, scan pointer and the response payload.
    laqs_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule

@@ dv/tb_linear_array_queue_with_search_core.sv @@
// Testbench for the linear array queue with search: directed table, fill phase, random traffic.
module tb_linear_array_queue_with_search_core;

    // The fourth kind code has no name in the package; the block treats it as a no-op.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Random traffic length, and the response counts that frame the receiver hold-off
    // and the window with no idling on either side.
    localparam int RAND_ITEMS  = 560;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LO    = 450;
    localparam int QUIET_HI    = 560;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    laqs_pkg::req_t req;
    logic rsp_valid;
    logic rsp_ready;
    laqs_pkg::rsp_t rsp;

    linear_array_queue_with_search_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Queue shadow: contents, head and tail slots, empty flag and the next
    // slot an enqueue would write. The store is linear, so next_slot only
    // drops back to zero when the last entry leaves.
    // ------------------------------------------------------------------
    logic [laqs_pkg::DATA_W-1:0] shadow_mem [laqs_pkg::DEPTH];
    int                qhead;
    int                qtail;
    bit                q_empty;
    int                next_slot;

    // Responses still owed by the block, oldest first.
    laqs_pkg::rsp_t pending_rsp [$];

    int errors;
    int sent;
    int rsp_seen;

    // Directed stimulus table; known rows carry an expected response typed in.
    typedef struct {
        laqs_pkg::req_t r;
        bit   known;
        laqs_pkg::rsp_t exp;
    } dir_row_t;

    dir_row_t dir_rows [$];

    // Work out the response to one request and advance the shadow state.
    function automatic laqs_pkg::rsp_t queue_predict(laqs_pkg::req_t r);
        laqs_pkg::rsp_t o;
        bit   hit;
        o   = '0;
        hit = 1'b0;
        case (r.kind)
            laqs_pkg::KIND_ENQ:
            begin
                if (next_slot >= laqs_pkg::DEPTH)
                begin
                    o.status = laqs_pkg::ST_FULL;
                end
                else
                begin
                    if (q_empty)
                        qhead = 0;
                    qtail             = next_slot;
                    shadow_mem[laqs_pkg::IDX_W'(qtail)] = r.value;
                    next_slot         = qtail + 1;
                    q_empty           = 1'b0;
                    o.status          = laqs_pkg::ST_OK;
                end
            end
            laqs_pkg::KIND_DEQ:
            begin
                if (q_empty)
                begin
                    o.status = laqs_pkg::ST_EMPTY;
                end
                else
                begin
                    o.status = laqs_pkg::ST_OK;
                    o.data   = shadow_mem[laqs_pkg::IDX_W'(qhead)];
                    if (qhead == qtail)
                    begin
                        // Last entry left: back to the reset state.
                        qhead     = 0;
                        qtail     = 0;
                        next_slot = 0;
                        q_empty   = 1'b1;
                    end
                    else
                    begin
                        qhead = qhead + 1;
                    end
                end
            end
            laqs_pkg::KIND_SRCH:
            begin
                if (!q_empty)
                begin
                    for (int i = qhead; i <= qtail && !hit; i++)
                    begin
                        if (shadow_mem[laqs_pkg::IDX_W'(i)] == r.value)
                        begin
                            hit        = 1'b1;
                            o.position = i[laqs_pkg::POS_W-1:0];
                        end
                    end
                end
                o.status = hit ? laqs_pkg::ST_OK : laqs_pkg::ST_NOTFOUND;
            end
            default:
            begin
                o.status = laqs_pkg::ST_OK;
            end
        endcase
        return o;
    endfunction

    function automatic void add_row(logic [1:0] k, logic [laqs_pkg::DATA_W-1:0] v,
                                    bit known, logic [1:0] st,
                                    logic [laqs_pkg::DATA_W-1:0] d,
                                    logic [laqs_pkg::POS_W-1:0] p);
        dir_row_t row;
        row.r.kind       = k;
        row.r.value      = v;
        row.known        = known;
        row.exp.status   = st;
        row.exp.data     = d;
        row.exp.position = p;
        dir_rows.push_back(row);
    endfunction

    // Values lean on a small pool so that searches meet duplicates, with the
    // signed extremes mixed in and full-width random words for bit coverage.
    function automatic logic [laqs_pkg::DATA_W-1:0] pick_value();
        logic [laqs_pkg::DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7fff_ffff;
            2, 3, 4: v = $urandom_range(0, 7);
            5:       v = 32'hffff_ffff;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Search mostly for a value that sits between head and tail.
    function automatic logic [laqs_pkg::DATA_W-1:0] pick_search_value();
        if (!q_empty && $urandom_range(0, 3) != 0)
            return shadow_mem[laqs_pkg::IDX_W'($urandom_range(qhead, qtail))];
        return pick_value();
    endfunction

    // Offer one request at the falling edge and hold it until the block takes it.
    // Predict at the accepting edge so the shadow stays in step with the block.
    task automatic push_request(laqs_pkg::req_t r, bit known, laqs_pkg::rsp_t exp);
        laqs_pkg::rsp_t pred;
        @(negedge clk);
        req_valid = 1'b1;
        req       = r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        pred = queue_predict(r);
        pending_rsp.push_back(known ? exp : pred);
        sent++;
    endtask

    // Drop valid for a few cycles, outside the window with no idling.
    task automatic maybe_idle_sender();
        int n;
        if (sent >= QUIET_LO && sent < QUIET_HI)
            return;
        if ($urandom_range(0, 99) < 11)
        begin
            n = $urandom_range(1, 4);
            repeat (n)
            begin
                @(negedge clk);
                req_valid = 1'b0;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Response checker: compare every accepted response against the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        laqs_pkg::rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            rsp_seen++;
            if (pending_rsp.size() == 0)
            begin
                errors++;
                $display("%0t: response with none expected: status %0d data %h position %0d",
                         $time, rsp.status, rsp.data, rsp.position);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.status !== want.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, rsp.status);
                end
                if (rsp.data !== want.data)
                begin
                    errors++;
                    $display("%0t: data expected %h actual %h", $time, want.data, rsp.data);
                end
                if (rsp.position !== want.position)
                begin
                    errors++;
                    $display("%0t: position expected %0d actual %0d",
                             $time, want.position, rsp.position);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random backpressure, one long hold-off so the block fills
    // its output register and stalls requests, and a stretch with none.
    // ------------------------------------------------------------------
    int hold_left;
    bit hold_done;

    initial
    begin
        rsp_ready = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && rsp_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready = 1'b0;
            end
            else if (rsp_seen >= QUIET_LO && rsp_seen < QUIET_HI)
            begin
                rsp_ready = 1'b1;
            end
            else
            begin
                rsp_ready = ($urandom_range(0, 99) >= 11);
            end
        end
    end

    // Hard stop well past the slowest legal run.
    initial
    begin
        #6000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        laqs_pkg::req_t r;
        laqs_pkg::rsp_t none;
        int   enq_w;
        int   pick;
        logic [laqs_pkg::DATA_W-1:0] deep_val;

        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        errors    = 0;
        sent      = 0;
        rsp_seen  = 0;
        qhead     = 0;
        qtail     = 0;
        q_empty   = 1'b1;
        next_slot = 0;
        none      = '0;

        // Directed table. Empty-queue cases, the unused kind and plain enqueues
        // have obvious answers; searches and most pops go through the shadow.
        add_row(laqs_pkg::KIND_DEQ,  32'h0000_0000, 1, laqs_pkg::ST_EMPTY,    32'h0, 7'd0);
        add_row(laqs_pkg::KIND_SRCH, 32'h0000_0000, 1, laqs_pkg::ST_NOTFOUND, 32'h0, 7'd0);
        add_row(KIND_UNUSED,         32'hffff_ffff, 1, laqs_pkg::ST_OK,       32'h0, 7'd0);
        add_row(laqs_pkg::KIND_ENQ,  32'h8000_0000, 1, laqs_pkg::ST_OK,       32'h0, 7'd0);
        add_row(laqs_pkg::KIND_ENQ,  32'h7fff_ffff, 1, laqs_pkg::ST_OK,       32'h0, 7'd0);
        add_row(laqs_pkg::KIND_ENQ,  32'h0000_0000, 1, laqs_pkg::ST_OK,       32'h0, 7'd0);
        add_row(laqs_pkg::KIND_ENQ,  32'hffff_ffff, 1, laqs_pkg::ST_OK,       32'h0, 7'd0);
        add_row(laqs_pkg::KIND_ENQ,  32'h7fff_ffff, 1, laqs_pkg::ST_OK,       32'h0, 7'd0);
        add_row(laqs_pkg::KIND_SRCH, 32'h7fff_ffff, 0, laqs_pkg::ST_OK,       32'h0, 7'd0);
        add_row(laqs_pkg::KIND_SRCH, 32'hffff_ffff, 0, laqs_pkg::ST_OK,       32'h0, 7'd0);
        add_row(laqs_pkg::KIND_SRCH, 32'h0001_2345, 0, laqs_pkg::ST_OK,       32'h0, 7'd0);
        add_row(laqs_pkg::KIND_DEQ,  32'hdead_beef, 1, laqs_pkg::ST_OK,
                32'h8000_0000, 7'd0);
        add_row(laqs_pkg::KIND_SRCH, 32'h8000_0000, 0, laqs_pkg::ST_OK,       32'h0, 7'd0);
        add_row(KIND_UNUSED,         32'h0000_0000, 1, laqs_pkg::ST_OK,       32'h0, 7'd0);
        add_row(laqs_pkg::KIND_DEQ,  32'h0000_0000, 0, laqs_pkg::ST_OK,       32'h0, 7'd0);
        add_row(laqs_pkg::KIND_DEQ,  32'hffff_ffff, 0, laqs_pkg::ST_OK,       32'h0, 7'd0);
        add_row(laqs_pkg::KIND_DEQ,  32'h0000_0000, 0, laqs_pkg::ST_OK,       32'h0, 7'd0);
        add_row(laqs_pkg::KIND_DEQ,  32'h0000_0000, 0, laqs_pkg::ST_OK,       32'h0, 7'd0);
        add_row(laqs_pkg::KIND_DEQ,  32'h0000_0000, 1, laqs_pkg::ST_EMPTY,    32'h0, 7'd0);
        add_row(laqs_pkg::KIND_SRCH, 32'h7fff_ffff, 1, laqs_pkg::ST_NOTFOUND, 32'h0, 7'd0);
        add_row(laqs_pkg::KIND_ENQ,  32'h0000_0005, 1, laqs_pkg::ST_OK,       32'h0, 7'd0);
        add_row(laqs_pkg::KIND_SRCH, 32'h0000_0005, 0, laqs_pkg::ST_OK,       32'h0, 7'd0);
        add_row(laqs_pkg::KIND_DEQ,  32'h0000_0000, 0, laqs_pkg::ST_OK,       32'h0, 7'd0);

        // Hold reset, then release it at a falling edge.
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
        begin
            maybe_idle_sender();
            push_request(dir_rows[i].r, dir_rows[i].known, dir_rows[i].exp);
        end

        // Fill phase: write every slot, then hit full, search the last slot
        // (longest scan), pop a few and show the freed slots stay unusable.
        while (next_slot < laqs_pkg::DEPTH)
        begin
            maybe_idle_sender();
            r.kind  = laqs_pkg::KIND_ENQ;
            r.value = (next_slot == laqs_pkg::DEPTH - 1) ? 32'h5a5a_a5a5 : pick_value();
            push_request(r, 0, none);
        end
        deep_val = shadow_mem[laqs_pkg::IDX_W'(laqs_pkg::DEPTH - 1)];
        r.kind   = laqs_pkg::KIND_ENQ;
        r.value  = $urandom;
        push_request(r, 0, none);
        push_request(r, 0, none);
        r.kind  = laqs_pkg::KIND_SRCH;
        r.value = deep_val;
        push_request(r, 0, none);
        repeat (3)
        begin
            r.kind  = laqs_pkg::KIND_DEQ;
            r.value = $urandom;
            push_request(r, 0, none);
        end
        r.kind  = laqs_pkg::KIND_ENQ;
        r.value = $urandom;
        push_request(r, 0, none);
        r.kind  = laqs_pkg::KIND_SRCH;
        r.value = deep_val;
        push_request(r, 0, none);

        // Random traffic in bursts of shifting enqueue bias, so the queue
        // swings between empty, shallow and full.
        enq_w = 50;
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       enq_w = 25;
                    1:       enq_w = 50;
                    default: enq_w = 75;
                endcase
            end
            pick = $urandom_range(0, 99);
            if (pick < 3)
            begin
                r.kind  = KIND_UNUSED;
                r.value = $urandom;
            end
            else if ($urandom_range(0, 99) < enq_w)
            begin
                r.kind  = laqs_pkg::KIND_ENQ;
                r.value = pick_value();
            end
            else if ($urandom_range(0, 99) < 60)
            begin
                r.kind  = laqs_pkg::KIND_DEQ;
                r.value = $urandom;
            end
            else
            begin
                r.kind  = laqs_pkg::KIND_SRCH;
                r.value = pick_search_value();
            end
            maybe_idle_sender();
            push_request(r, 0, none);
        end

        // Drop valid, drain, then allow a full scan's worth of cycles for strays.
        @(negedge clk);
        req_valid = 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (laqs_pkg::DEPTH + 20) @(posedge clk);

        if (errors == 0 && pending_rsp.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
